[design/dq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes and defaults for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

endpackage
`default_nettype wire

[design/double_ended_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed values held in a ring memory of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation and push_value with start high; the beat
//   is taken at an edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle; status, popped_value,
//   front_value, rear_value, occupancy and is_empty are valid in that cycle.
//   The receiver cannot stall, so results are never held back.
// Timing and throughput:
//   Push, peek, overflow, underflow and a pop that empties the queue: result
//   in the cycle after the accept, a new command every cycle.
//   A pop that leaves entries behind: the new front (or rear) is read from
//   the ring memory into rd_data_q, then the ST_FETCH state copies it into
//   the cached end register and raises done; busy is high for one cycle.
//   Front and rear values are cached in registers; the memory read port
//   only serves the refill after a pop.
// Reset: head and count go to zero (queue empty); the ring contents are not
//   cleared, an entry is read only after a push has written it.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [dq_pkg::OP_W-1:0]          operation,
	input  wire  signed [DATA_WIDTH-1:0]     push_value,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [DATA_WIDTH-1:0]     popped_value,
	output logic signed [DATA_WIDTH-1:0]     front_value,
	output logic signed [DATA_WIDTH-1:0]     rear_value,
	output logic [$clog2(DEPTH+1)-1:0]       occupancy,
	output logic                             is_empty
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH-1);

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic signed [DATA_WIDTH-1:0] ring_mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_data_q;

	state_t                       state_q;
	logic [IDX_W-1:0]             head_q;
	logic [CNT_W-1:0]             count_q;
	logic signed [DATA_WIDTH-1:0] front_q;
	logic signed [DATA_WIDTH-1:0] rear_q;
	logic                         fetch_front_q;
	logic                         done_q;
	status_t                      status_q;
	logic signed [DATA_WIDTH-1:0] popped_q;

	logic                         accept;
	logic                         q_empty;
	logic                         q_full;
	logic [IDX_W-1:0]             head_inc;
	logic [IDX_W-1:0]             head_dec;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;

	assign accept   = start && !busy;
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == DEPTH_C);
	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? IDX_LAST : head_q - 1'b1;

	// memory port control; a refill read is needed only when entries remain
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_dec;
		rd_en   = 1'b0;
		rd_addr = head_inc;
		if (accept) begin
			unique case (operation)
				OP_PUSH_FRONT: begin
					wr_en   = !q_full;
					wr_addr = head_dec;
				end
				OP_PUSH_REAR: begin
					wr_en   = !q_full;
					wr_addr = ring_add(head_q, count_q[IDX_W-1:0]);
				end
				OP_POP_FRONT: begin
					rd_en   = (count_q > CNT_W'(1));
					rd_addr = head_inc;
				end
				OP_POP_REAR: begin
					rd_en   = (count_q > CNT_W'(1));
					rd_addr = ring_add(head_q, IDX_W'(count_q - CNT_W'(2)));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= !rd_en;
						if (rd_en) begin
							state_q <= ST_FETCH;
						end
						unique case (operation)
							OP_PUSH_FRONT: begin
								if (!q_full) begin
									head_q  <= head_dec;
									count_q <= count_q + 1'b1;
								end
							end
							OP_PUSH_REAR: begin
								if (!q_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_POP_FRONT: begin
								if (!q_empty) begin
									head_q  <= head_inc;
									count_q <= count_q - 1'b1;
								end
							end
							OP_POP_REAR: begin
								if (!q_empty) begin
									count_q <= count_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload and cached end values
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= STAT_OK;
			popped_q <= '1;
			unique case (operation)
				OP_PUSH_FRONT: begin
					if (q_full) begin
						status_q <= STAT_OVERFLOW;
					end else begin
						front_q <= push_value;
						if (q_empty) begin
							rear_q <= push_value;
						end
					end
				end
				OP_PUSH_REAR: begin
					if (q_full) begin
						status_q <= STAT_OVERFLOW;
					end else begin
						rear_q <= push_value;
						if (q_empty) begin
							front_q <= push_value;
						end
					end
				end
				OP_POP_FRONT: begin
					fetch_front_q <= 1'b1;
					if (q_empty) begin
						status_q <= STAT_UNDERFLOW;
					end else begin
						popped_q <= front_q;
					end
				end
				OP_POP_REAR: begin
					fetch_front_q <= 1'b0;
					if (q_empty) begin
						status_q <= STAT_UNDERFLOW;
					end else begin
						popped_q <= rear_q;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_FETCH) begin
			if (fetch_front_q) begin
				front_q <= rd_data_q;
			end else begin
				rear_q <= rd_data_q;
			end
		end
	end

	assign busy         = (state_q == ST_FETCH);
	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = q_empty ? '0 : front_q;
	assign rear_value   = q_empty ? '0 : rear_q;
	assign occupancy    = count_q;
	assign is_empty     = q_empty;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_fetch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> (!done_q ##1 done_q))
		else $error("refill cycle did not end in a result");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
			count_q == $past(count_q) - 1'b1))
		else $error("count moved by more than one entry");

	a_refill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> !q_empty)
		else $error("refill started on an empty queue");

endmodule
`default_nettype wire
